// File: hdl/d2l_pkg.sv
// Shared types, codes and helpers for the DNS-to-LDAP escape converter.
package d2l_pkg;

	// Escape parser phase
	typedef enum logic [1:0] {
		PH_PLAIN = 2'd0,
		PH_ESC   = 2'd1,
		PH_DEC1  = 2'd2,
		PH_DEC2  = 2'd3
	} d2l_phase_t;

	// Work item kind passed from front to back
	typedef enum logic [1:0] {
		CMD_PLAIN = 2'd0,
		CMD_HEX   = 2'd1,
		CMD_BAD   = 2'd2
	} d2l_kind_t;

	typedef struct packed {
		d2l_kind_t  kind;
		logic [7:0] value;
		logic       last;
	} d2l_cmd_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_NINE      = 8'h39;
	localparam logic [7:0] CH_LOWER_A   = 8'h61;
	localparam logic [9:0] MAX_DEC      = 10'd255;

	// Lowercase hex character for one nibble
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = CH_ZERO + {4'd0, nib};
		end else begin
			r = CH_LOWER_A + {4'd0, nib} - 8'd10;
		end
		return r;
	endfunction

endpackage

// File: hdl/dns_to_ldap_escape_converter_top.sv
// Top level of the DNS-to-LDAP escape converter.
//
// Input channel (in_valid/in_ready, in_byte, in_last) takes one word per
// cycle of DNS-escaped text while the queue is not full; in_last marks the
// final byte of a name. Output channel (out_valid/out_ready, out_byte,
// out_last, bad_escape) gives the LDAP-escaped text one word per cycle while
// words are waiting and the receiver is ready. A malformed escape ends the
// name with one word carrying bad_escape = 1 and out_last = 1; the rest of
// that name's input is dropped. The first output word of an input passes
// through the work queue and then the output register. A plain byte gives
// one output word, a byte rendered in hex form gives three (a backslash and
// two lowercase hex digits). A four-entry work queue lets the parser keep
// taking input while the output side expands earlier words.
// When the receiver stalls, the output word holds and the queue fills;
// in_ready drops only when the queue is full.
// Reset clears the escape state, the queue and the output valid.
module dns_to_ldap_escape_converter_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       bad_escape
);
	import d2l_pkg::*;

	logic     q_full;
	logic     q_push;
	logic     q_pop;
	logic     q_empty;
	d2l_cmd_t push_cmd;
	d2l_cmd_t head_cmd;

	d2l_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	d2l_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head_cmd (head_cmd)
	);

	d2l_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_cmd      (head_cmd),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.bad_escape (bad_escape)
	);

endmodule

// File: hdl/d2l_front.sv
// Front end: accepts input words, tracks escape state and issues work items.
module d2l_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  logic              q_full,
	output logic              q_push,
	output d2l_pkg::d2l_cmd_t q_cmd
);
	import d2l_pkg::*;

	d2l_phase_t phase_q, phase_d;
	logic [6:0] partial_q, partial_d;
	logic       discard_q, discard_d;

	logic       accept;
	logic       digit;
	logic       plain;
	logic [3:0] dval;
	logic [9:0] dec_value;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Classify the incoming byte
	assign digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
	assign dval  = digit ? in_byte[3:0] : 4'd0;
	assign plain = in_byte inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a],
		8'h2e, 8'h2d, 8'h5f};

	// Accumulate decimal value: partial * 10 + digit
	assign dec_value = {partial_q, 3'b000} + {2'b00, partial_q, 1'b0} + {6'd0, dval};

	// Hold state between edges
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_PLAIN;
			partial_q <= '0;
			discard_q <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			partial_q <= partial_d;
			discard_q <= discard_d;
		end
	end

	// Next state and work item
	always_comb begin
		phase_d   = phase_q;
		partial_d = partial_q;
		discard_d = discard_q;
		q_push    = 1'b0;
		q_cmd     = '{kind: CMD_BAD, value: 8'd0, last: 1'b1};
		if (accept) begin
			if (discard_q) begin
				if (in_last) begin
					discard_d = 1'b0;
					phase_d   = PH_PLAIN;
					partial_d = '0;
				end
			end else begin
				case (phase_q)
					PH_PLAIN: begin
						if (plain) begin
							q_push = 1'b1;
							q_cmd  = '{kind: CMD_PLAIN, value: in_byte, last: in_last};
						end else if (in_byte == CH_BACKSLASH) begin
							if (in_last) begin
								q_push = 1'b1;
							end else begin
								phase_d = PH_ESC;
							end
						end else begin
							q_push = 1'b1;
							q_cmd  = '{kind: CMD_HEX, value: in_byte, last: in_last};
						end
					end
					PH_ESC: begin
						if (digit) begin
							if (in_last) begin
								q_push  = 1'b1;
								phase_d = PH_PLAIN;
							end else begin
								partial_d = {3'd0, dval};
								phase_d   = PH_DEC1;
							end
						end else begin
							phase_d = PH_PLAIN;
							q_push  = 1'b1;
							q_cmd   = '{kind: CMD_HEX, value: in_byte, last: in_last};
						end
					end
					PH_DEC1: begin
						if (!digit || in_last) begin
							q_push    = 1'b1;
							phase_d   = PH_PLAIN;
							partial_d = '0;
							discard_d = !in_last;
						end else begin
							partial_d = dec_value[6:0];
							phase_d   = PH_DEC2;
						end
					end
					PH_DEC2: begin
						q_push    = 1'b1;
						phase_d   = PH_PLAIN;
						partial_d = '0;
						if (!digit || (dec_value > MAX_DEC)) begin
							discard_d = !in_last;
						end else begin
							q_cmd = '{kind: CMD_HEX, value: dec_value[7:0], last: in_last};
						end
					end
					default: begin
						phase_d = PH_PLAIN;
					end
				endcase
			end
		end
	end

endmodule

// File: hdl/d2l_queue.sv
// Short work-item queue between front and back.
module d2l_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  d2l_pkg::d2l_cmd_t push_cmd,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output d2l_pkg::d2l_cmd_t head_cmd
);
	import d2l_pkg::*;

	d2l_cmd_t            mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full     = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign head_cmd = mem_q[rd_ptr_q];

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hdl/d2l_back.sv
// Back end: expands work items into output words through an output register.
module d2l_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  d2l_pkg::d2l_cmd_t q_cmd,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              out_last,
	output logic              bad_escape
);
	import d2l_pkg::*;

	logic [1:0] step_q, step_d;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       bad_q;

	logic       load;
	logic [7:0] byte_d;
	logic       last_d;
	logic       bad_d;

	assign out_valid  = valid_q;
	assign out_byte   = byte_q;
	assign out_last   = last_q;
	assign bad_escape = bad_q;

	// Refill the output register when it is empty or being taken
	assign load = !valid_q || out_ready;

	// Pick the next output word from the head item
	always_comb begin
		byte_d = 8'd0;
		last_d = 1'b1;
		bad_d  = 1'b1;
		step_d = step_q;
		q_pop  = 1'b0;
		if (load && !q_empty) begin
			case (q_cmd.kind)
				CMD_PLAIN: begin
					byte_d = q_cmd.value;
					last_d = q_cmd.last;
					bad_d  = 1'b0;
					q_pop  = 1'b1;
				end
				CMD_HEX: begin
					bad_d  = 1'b0;
					last_d = 1'b0;
					case (step_q)
						2'd0: begin
							byte_d = CH_BACKSLASH;
							step_d = 2'd1;
						end
						2'd1: begin
							byte_d = hex_char(q_cmd.value[7:4]);
							step_d = 2'd2;
						end
						default: begin
							byte_d = hex_char(q_cmd.value[3:0]);
							last_d = q_cmd.last;
							step_d = 2'd0;
							q_pop  = 1'b1;
						end
					endcase
				end
				default: begin
					q_pop = 1'b1;
				end
			endcase
		end
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q  <= 2'd0;
		end else begin
			step_q <= step_d;
			if (load) begin
				valid_q <= !q_empty;
			end
		end
	end

	// Load output payload
	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			byte_q <= byte_d;
			last_q <= last_d;
			bad_q  <= bad_d;
		end
	end

endmodule
